>>> design/assert_macros.svh
// Assertion macros shared by the ordered list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define OLIR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define OLIR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/olir_pkg.sv
// Package with opcodes, status codes and cell control types of the ordered list.
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

	localparam int OPCODE_BITS = 3;
	localparam int INDEX_BITS  = 7;
	localparam int VALUE_BITS  = 32;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 7;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_INSERT     = 3'd0,
		OP_APPEND     = 3'd1,
		OP_REPLACE    = 3'd2,
		OP_REMOVE_IDX = 3'd3,
		OP_REMOVE_VAL = 3'd4,
		OP_GET        = 3'd5
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_BOUNDS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_INSERT     = 2'd1,
		ACT_WRITE      = 2'd2,
		ACT_SHIFT_DOWN = 2'd3
	} act_t;

	typedef struct packed {
		logic cmp_en;
		logic by_value;
		act_t act;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/olir_cell.sv
// One list cell: holds an entry, compares it, and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module olir_cell import olir_pkg::*; #(
	parameter int IDX = 0,
	parameter int PW  = 7,
	parameter int EW  = 32
) (
	input  wire logic          clk,
	input  wire cell_ctrl_t    ctrl,
	input  wire logic [PW-1:0] pos,
	input  wire logic [PW-1:0] count,
	input  wire logic [EW-1:0] value,
	input  wire logic          shift_dn,
	input  wire logic [EW-1:0] below,
	input  wire logic [EW-1:0] above,
	output logic      [EW-1:0] entry,
	output logic               mark,
	output logic      [EW-1:0] rd_part
);

	localparam logic [PW-1:0] MY = PW'(IDX);

	logic [EW-1:0] entry_q;
	logic          match_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			if (ctrl.by_value) begin
				match_q <= (entry_q == value) && (MY < count);
			end else begin
				match_q <= (MY == pos);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ACT_INSERT: begin
				if (MY > pos) begin
					entry_q <= below;
				end else if (MY == pos) begin
					entry_q <= value;
				end
			end
			ACT_WRITE: begin
				if (MY == pos) begin
					entry_q <= value;
				end
			end
			ACT_SHIFT_DOWN: begin
				if (shift_dn) begin
					entry_q <= above;
				end
			end
			ACT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign entry   = entry_q;
	assign mark    = match_q;
	assign rd_part = match_q ? entry_q : '0;

endmodule

`default_nettype wire

>>> design/ordered_list_insert_remove.sv
// Ordered list engine: a row of entry cells under a small sequencer.
// Usage: one input transaction carries opcode, index and element_value; each
// yields exactly one output transaction with status, read_value and
// entry_count. Both channels use valid and stall; a transaction moves at a
// rising edge with valid high and stall low.
// Flow: the sequencer first registers the compare in every cell, then
// applies the shift and loads the output register; a new operation is
// accepted only once the previous one has left its apply step.
// The input side stalls while an operation is in flight; a finished result
// waits in the output register while the next operation is accepted.
// If the receiver stalls with a result still held, the following operation
// pauses in its apply step until the output register frees.
// Reset clears the entry count, the sequencer and the output valid; entry
// contents are not cleared and are only read after being written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_list_insert_remove import olir_pkg::*; #(
	parameter int CAPACITY     = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [OPCODE_BITS-1:0] opcode,
	input  wire logic [INDEX_BITS-1:0]  index,
	input  wire logic [VALUE_BITS-1:0]  element_value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [STATUS_BITS-1:0]      status,
	output logic [VALUE_BITS-1:0]       read_value,
	output logic [COUNT_BITS-1:0]       entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam int LV = $clog2(CAPACITY);
	localparam int EW = ELEMENT_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [PW-1:0] pos_q;
	logic [EW-1:0] val_q;
	logic [CW-1:0] count_q;

	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [VALUE_BITS-1:0]  read_value_q;
	logic [COUNT_BITS-1:0]  entry_count_q;

	logic                in_fire;
	logic                adv;
	logic [PW-1:0]       count_pw;
	logic [EW+31:0]      val_ext;
	cell_ctrl_t          ctrl;
	act_t                act;
	status_t             st;
	logic [CW-1:0]       count_nxt;
	logic                full;
	logic                found;
	logic [CAPACITY-1:0] marks;
	logic [CAPACITY-1:0] pre;
	logic [EW-1:0]       rd_or;
	logic [EW+31:0]      rd_ext;
	logic [CW+6:0]       cnt_ext;

	logic [EW-1:0] cell_entry [CAPACITY];
	logic [EW-1:0] cell_rd    [CAPACITY];

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign adv      = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign count_pw = PW'(count_q);
	assign val_ext  = {{EW{1'b0}}, element_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= opcode;
			val_q <= val_ext[EW-1:0];
			if (opcode == OP_APPEND) begin
				pos_q <= count_pw;
			end else begin
				pos_q <= PW'(index);
			end
		end
	end

	always_comb begin
		pre = marks;
		for (int l = 0; l < LV; l++) begin
			for (int i = CAPACITY - 1; i >= 0; i--) begin
				if (i >= (1 << l)) begin
					pre[i] = pre[i] | pre[i - (1 << l)];
				end
			end
		end
	end

	assign found = pre[CAPACITY-1];
	assign full  = (count_q == CW'(CAPACITY));

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_comb begin
		act       = ACT_NONE;
		st        = ST_OK;
		count_nxt = count_q;
		unique case (op_q)
			OP_INSERT, OP_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_q > count_pw) begin
					st = ST_BOUNDS;
				end else begin
					act       = ACT_INSERT;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_REPLACE: begin
				if (pos_q >= count_pw) begin
					st = ST_BOUNDS;
				end else begin
					act = ACT_WRITE;
				end
			end
			OP_REMOVE_IDX: begin
				if (pos_q >= count_pw) begin
					st = ST_BOUNDS;
				end else begin
					act       = ACT_SHIFT_DOWN;
					count_nxt = count_q - CW'(1);
				end
			end
			OP_REMOVE_VAL: begin
				if (!found) begin
					st = ST_NOTFOUND;
				end else begin
					act       = ACT_SHIFT_DOWN;
					count_nxt = count_q - CW'(1);
				end
			end
			OP_GET: begin
				if (pos_q >= count_pw) begin
					st = ST_BOUNDS;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctrl.cmp_en   = (state_q == S_CMP);
	assign ctrl.by_value = (op_q == OP_REMOVE_VAL);
	assign ctrl.act      = adv ? act : ACT_NONE;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [EW-1:0] below;
			logic [EW-1:0] above;
			if (g == 0) begin : g_first
				assign below = '0;
			end else begin : g_mid_lo
				assign below = cell_entry[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign above = '0;
			end else begin : g_mid_hi
				assign above = cell_entry[g+1];
			end
			olir_cell #(
				.IDX (g),
				.PW  (PW),
				.EW  (EW)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.pos      (pos_q),
				.count    (count_pw),
				.value    (val_q),
				.shift_dn (pre[g]),
				.below    (below),
				.above    (above),
				.entry    (cell_entry[g]),
				.mark     (marks[g]),
				.rd_part  (cell_rd[g])
			);
		end
	endgenerate

	assign rd_ext  = {32'b0, rd_or};
	assign cnt_ext = {7'b0, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q      <= st;
			entry_count_q <= cnt_ext[COUNT_BITS-1:0];
			if ((op_q == OP_GET) && (st == ST_OK)) begin
				read_value_q <= rd_ext[VALUE_BITS-1:0];
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

	`OLIR_ASSERT(a_count_max, (count_q <= CW'(CAPACITY)), "Entry count exceeds capacity.")
	`OLIR_ASSERT_IMP(a_count_in_exec, (count_q != $past(count_q)), $past(state_q == S_EXEC), "Count changed outside the apply step.")
	`OLIR_ASSERT_IMP(a_out_after_exec, $rose(out_valid_q), $past(state_q == S_EXEC), "Output became valid without an apply step.")
	`OLIR_ASSERT_IMP(a_get_onehot, ((state_q == S_EXEC) && (op_q != OP_REMOVE_VAL)), $onehot0(marks), "Index compare selected more than one cell.")

endmodule

`default_nettype wire
